// File: rtl/psrls_pkg.sv
// Shared types and constants for the PWM speed ramp with end-switch interlock.
package psrls_pkg;

   localparam int PWM_RANGE = 1024;
   localparam int SPEED_MAX = 1023;
   localparam int SPEED_LIM_INT = (PWM_RANGE - 1 < SPEED_MAX) ? PWM_RANGE - 1 : SPEED_MAX;

   localparam int SPEED_W = 11;
   localparam int DUTY_W = 10;
   localparam int TICKS_W = 8;
   localparam int CSR_IDX_W = 1;

   localparam logic signed [SPEED_W-1:0] SPEED_LIM = SPEED_W'(SPEED_LIM_INT);
   localparam logic [SPEED_W-1:0] DUTY_LIM = SPEED_W'(SPEED_LIM_INT);
   localparam logic [TICKS_W-1:0] START_TICKS_RST = TICKS_W'(5);
   localparam logic [TICKS_W-1:0] STOP_TICKS_RST = TICKS_W'(4);

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_SPEED = 2'd1,
      OP_LEFT_SW = 2'd2,
      OP_RIGHT_SW = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      BLK_FREE = 2'd0,
      BLK_LEFT = 2'd1,
      BLK_RIGHT = 2'd2
   } block_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_TICKS = 1'b0,
      CSR_STOP_TICKS = 1'b1
   } csr_index_type;

endpackage

// File: rtl/psrls_if.sv
// Handshake channel interfaces for commands, results and register writes.
interface psrls_req_if;
   import psrls_pkg::*;
   logic valid;
   logic ready;
   logic [1:0] opcode;
   logic signed [SPEED_W-1:0] speed_value;
   logic switch_closed;
   modport source (output valid, output opcode, output speed_value, output switch_closed,
                   input ready);
   modport sink (input valid, input opcode, input speed_value, input switch_closed,
                 output ready);
endinterface

interface psrls_rsp_if;
   import psrls_pkg::*;
   logic valid;
   logic ready;
   logic [DUTY_W-1:0] pwm_duty;
   logic direction_reverse;
   logic signed [SPEED_W-1:0] current_speed;
   logic [1:0] end_stop_state;
   logic command_ignored;
   modport source (output valid, output pwm_duty, output direction_reverse,
                   output current_speed, output end_stop_state, output command_ignored,
                   input ready);
   modport sink (input valid, input pwm_duty, input direction_reverse,
                 input current_speed, input end_stop_state, input command_ignored,
                 output ready);
endinterface

interface psrls_csr_if;
   import psrls_pkg::*;
   logic valid;
   logic ready;
   logic [CSR_IDX_W-1:0] index;
   logic [TICKS_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/pwm_speed_ramp_limit_switch.sv
// Top level: signed motor speed ramp with end-switch interlock and result register.
// An accepted item's result is in the output register in the cycle after it is accepted.
// Throughput: one item per cycle while results are drained; the ramp state updates in a single pass.
// A new item is taken whenever the result register is empty or being drained.
// Register writes are taken in any cycle.
// Reset clears the ramp state, the block status and the result valid flag, and loads the default tick periods.
module pwm_speed_ramp_limit_switch (
   input logic clock,
   input logic reset,
   psrls_req_if.sink req_chan,
   psrls_rsp_if.source rsp_chan,
   psrls_csr_if.sink csr_chan
);
   import psrls_pkg::*;

   logic [TICKS_W-1:0] start_ticks_ff, start_ticks_in;
   logic [TICKS_W-1:0] stop_ticks_ff, stop_ticks_in;
   logic signed [SPEED_W-1:0] speed_now_ff, speed_now_in;
   logic signed [SPEED_W-1:0] speed_target_ff, speed_target_in;
   logic [TICKS_W-1:0] step_timer_ff, step_timer_in;
   block_type block_status_ff, block_status_in;
   logic dir_reverse_ff, dir_reverse_in;
   logic soft_stopping_ff, soft_stopping_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0] rsp_duty_ff, rsp_duty_in;
   logic rsp_dir_ff;
   logic signed [SPEED_W-1:0] rsp_speed_ff;
   block_type rsp_status_ff;
   logic rsp_ignored_ff, rsp_ignored_in;

   logic req_fire;
   logic [TICKS_W-1:0] period;
   logic [TICKS_W-1:0] timer_inc;
   logic signed [SPEED_W-1:0] step_speed;
   logic signed [SPEED_W-1:0] req_sat;
   logic [SPEED_W-1:0] speed_mag;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   always_comb begin
      start_ticks_in = start_ticks_ff;
      stop_ticks_in = stop_ticks_ff;
      if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_START_TICKS: start_ticks_in = csr_chan.data;
            CSR_STOP_TICKS: stop_ticks_in = csr_chan.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      period = soft_stopping_ff ? stop_ticks_ff : start_ticks_ff;
      if (period == '0) begin
         period = TICKS_W'(1);
      end
      timer_inc = step_timer_ff + TICKS_W'(1);
      if (speed_now_ff < speed_target_ff) begin
         step_speed = speed_now_ff + SPEED_W'(1);
      end else if (speed_now_ff > speed_target_ff) begin
         step_speed = speed_now_ff - SPEED_W'(1);
      end else begin
         step_speed = speed_now_ff;
      end
      req_sat = req_chan.speed_value;
      if (req_sat > SPEED_LIM) begin
         req_sat = SPEED_LIM;
      end else if (req_sat < -SPEED_LIM) begin
         req_sat = -SPEED_LIM;
      end
   end

   always_comb begin
      speed_now_in = speed_now_ff;
      speed_target_in = speed_target_ff;
      step_timer_in = step_timer_ff;
      block_status_in = block_status_ff;
      dir_reverse_in = dir_reverse_ff;
      soft_stopping_in = soft_stopping_ff;
      rsp_ignored_in = 1'b0;
      if (req_fire) begin
         case (opcode_type'(req_chan.opcode))
            OP_TICK: begin
               if (soft_stopping_ff && speed_now_ff == '0) begin
                  soft_stopping_in = 1'b0;
                  dir_reverse_in = 1'b0;
                  step_timer_in = '0;
               end else if (!soft_stopping_ff && speed_now_ff == speed_target_ff) begin
                  step_timer_in = '0;
               end else if (timer_inc < period) begin
                  step_timer_in = timer_inc;
               end else begin
                  step_timer_in = '0;
                  speed_now_in = step_speed;
                  if (soft_stopping_ff) begin
                     if (step_speed == '0) begin
                        soft_stopping_in = 1'b0;
                        dir_reverse_in = 1'b0;
                     end
                  end else if (speed_now_ff == '0 || step_speed == '0) begin
                     dir_reverse_in = speed_target_ff[SPEED_W-1];
                  end
               end
            end
            OP_SPEED: begin
               if ((req_sat > 0 && block_status_ff == BLK_LEFT) ||
                   (req_sat < 0 && block_status_ff == BLK_RIGHT)) begin
                  rsp_ignored_in = 1'b1;
               end else begin
                  soft_stopping_in = (req_sat == '0);
                  speed_target_in = req_sat;
                  step_timer_in = '0;
               end
            end
            OP_LEFT_SW, OP_RIGHT_SW: begin
               if (req_chan.switch_closed) begin
                  block_status_in = (req_chan.opcode == OP_LEFT_SW) ? BLK_LEFT : BLK_RIGHT;
                  speed_now_in = '0;
                  speed_target_in = '0;
                  soft_stopping_in = 1'b0;
                  step_timer_in = '0;
               end else begin
                  block_status_in = BLK_FREE;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      speed_mag = speed_now_in[SPEED_W-1] ? SPEED_W'(-speed_now_in) : SPEED_W'(speed_now_in);
      if (speed_mag > DUTY_LIM) begin
         speed_mag = DUTY_LIM;
      end
      rsp_duty_in = speed_mag[DUTY_W-1:0];
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ticks_ff <= START_TICKS_RST;
         stop_ticks_ff <= STOP_TICKS_RST;
         speed_now_ff <= '0;
         speed_target_ff <= '0;
         step_timer_ff <= '0;
         block_status_ff <= BLK_FREE;
         dir_reverse_ff <= 1'b0;
         soft_stopping_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ticks_ff <= start_ticks_in;
         stop_ticks_ff <= stop_ticks_in;
         speed_now_ff <= speed_now_in;
         speed_target_ff <= speed_target_in;
         step_timer_ff <= step_timer_in;
         block_status_ff <= block_status_in;
         dir_reverse_ff <= dir_reverse_in;
         soft_stopping_ff <= soft_stopping_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_duty_ff <= rsp_duty_in;
         rsp_dir_ff <= dir_reverse_in;
         rsp_speed_ff <= speed_now_in;
         rsp_status_ff <= block_status_in;
         rsp_ignored_ff <= rsp_ignored_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.pwm_duty = rsp_duty_ff;
   assign rsp_chan.direction_reverse = rsp_dir_ff;
   assign rsp_chan.current_speed = rsp_speed_ff;
   assign rsp_chan.end_stop_state = rsp_status_ff;
   assign rsp_chan.command_ignored = rsp_ignored_ff;

endmodule

// File: rtl/psrls_chk.sv
// Port-level checker for the speed ramp, attached to the top level by bind.
module psrls_chk (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic [1:0] req_opcode,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [psrls_pkg::DUTY_W-1:0] rsp_pwm_duty,
   input logic signed [psrls_pkg::SPEED_W-1:0] rsp_current_speed,
   input logic [1:0] rsp_end_stop_state,
   input logic rsp_command_ignored
);
   import psrls_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_current_speed))
      else $error("Result item dropped or changed while stalled.");

   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("Accepted item produced no result.");

   a_duty_mag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pwm_duty == (rsp_current_speed[SPEED_W-1] ?
         DUTY_W'(-rsp_current_speed) : DUTY_W'(rsp_current_speed)))
      else $error("Duty does not match speed magnitude.");

   a_ignored_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode != OP_SPEED |=> !rsp_command_ignored)
      else $error("Ignore flag set on an item that is not a speed command.");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_end_stop_state != 2'd3)
      else $error("Invalid end-stop status.");

endmodule

bind pwm_speed_ramp_limit_switch psrls_chk u_psrls_chk (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .req_opcode(req_chan.opcode),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_pwm_duty(rsp_chan.pwm_duty),
   .rsp_current_speed(rsp_chan.current_speed),
   .rsp_end_stop_state(rsp_chan.end_stop_state),
   .rsp_command_ignored(rsp_chan.command_ignored)
);
